// File: design/arwc_pkg.sv
// ----------------------------------------------------------------------------
// arwc_pkg: shared types and constants for the anti-replay window check
// Holds the window geometry, register indexes, verdict codes and the item,
// result, window state and configuration structures.
// ----------------------------------------------------------------------------
package arwc_pkg;

    localparam int WIN_SIZE = 64;
    localparam int WIN_IDX_W = $clog2(WIN_SIZE);
    localparam logic [31:0] WIN_SIZE_32 = 32'(WIN_SIZE);
    localparam logic [WIN_SIZE-1:0] WIN_ONE = {{(WIN_SIZE-1){1'b0}}, 1'b1};

    localparam int IN_TDATA_W = 128;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_UNDERFLOW_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REGEN_INTERVAL = 1'd1;

    localparam logic [3:0] UNDERFLOW_LIMIT_RESET = 4'd8;
    localparam logic [31:0] REGEN_INTERVAL_RESET = 32'd3000;

    typedef enum logic [2:0] {
        VERDICT_NEW_TOP   = 3'd0,
        VERDICT_IN_WINDOW = 3'd1,
        VERDICT_BAD       = 3'd2,
        VERDICT_DUPLICATE = 3'd3,
        VERDICT_TOO_OLD   = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [31:0] current_nonce;
        logic [31:0] packet_nonce;
        logic [31:0] packet_counter;
        logic [31:0] time_ms;
    } item_t;

    typedef struct packed {
        logic     accepted;
        verdict_t verdict;
        logic     regen_request;
    } result_t;

    typedef struct packed {
        logic [31:0]         window_nonce;
        logic [31:0]         window_top;
        logic [WIN_SIZE-1:0] seen_bitmap;
        logic [3:0]          underflow_count;
        logic [31:0]         last_regen_time;
    } win_state_t;

    typedef struct packed {
        logic [3:0]  underflow_limit;
        logic [31:0] regen_interval_ms;
    } cfg_t;

endpackage

// File: design/arwc_state.sv
// ----------------------------------------------------------------------------
// arwc_state: configuration and window state registers
// Holds the two configuration registers and the sliding window state, and
// loads the next window state when an item is judged.
// ----------------------------------------------------------------------------
module arwc_state (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [arwc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [arwc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               upd_en,
    input  arwc_pkg::win_state_t               state_next,
    output arwc_pkg::win_state_t               state_q,
    output arwc_pkg::cfg_t                     cfg_q
);
    import arwc_pkg::*;

    win_state_t state_reg;
    cfg_t       cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (upd_en) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.underflow_limit   <= UNDERFLOW_LIMIT_RESET;
            cfg_reg.regen_interval_ms <= REGEN_INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_UNDERFLOW_LIMIT: cfg_reg.underflow_limit <= cfg_wdata[3:0];
                REG_REGEN_INTERVAL: cfg_reg.regen_interval_ms <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    assign state_q = state_reg;
    assign cfg_q   = cfg_reg;

endmodule

// File: design/arwc_judge.sv
// ----------------------------------------------------------------------------
// arwc_judge: combinational packet judgment against the window
// Rebinds the window on a nonce change, classifies the packet counter and
// forms the result together with the next window state.
// ----------------------------------------------------------------------------
module arwc_judge (
    input  arwc_pkg::item_t      item,
    input  arwc_pkg::win_state_t state_q,
    input  arwc_pkg::cfg_t       cfg_q,
    output arwc_pkg::win_state_t state_next,
    output arwc_pkg::result_t    result
);
    import arwc_pkg::*;

    logic                 nonce_chg;
    logic [31:0]          top_e;
    logic [WIN_SIZE-1:0]  bitmap_e;
    logic [3:0]           count_e;
    logic [3:0]           count_inc;
    logic [31:0]          shift_amt;
    logic [31:0]          distance;
    logic [31:0]          elapsed;
    logic [WIN_SIZE-1:0]  dist_bit;

    always_comb begin
        nonce_chg = item.current_nonce != state_q.window_nonce;
        top_e     = nonce_chg ? 32'd0 : state_q.window_top;
        bitmap_e  = nonce_chg ? '0 : state_q.seen_bitmap;
        count_e   = nonce_chg ? 4'd0 : state_q.underflow_count;
        count_inc = count_e + 4'd1;
        shift_amt = item.packet_counter - top_e;
        distance  = top_e - item.packet_counter;
        elapsed   = item.time_ms - state_q.last_regen_time;
        dist_bit  = WIN_ONE << distance[WIN_IDX_W-1:0];

        state_next.window_nonce    = item.current_nonce;
        state_next.window_top      = top_e;
        state_next.seen_bitmap     = bitmap_e;
        state_next.underflow_count = count_e;
        state_next.last_regen_time = state_q.last_regen_time;

        result.accepted      = 1'b0;
        result.verdict       = VERDICT_BAD;
        result.regen_request = 1'b0;

        priority if (item.packet_nonce != item.current_nonce
                     || item.packet_counter == 32'd0) begin
            result.verdict = VERDICT_BAD;
        end else if (item.packet_counter > top_e) begin
            if (shift_amt >= WIN_SIZE_32) begin
                state_next.seen_bitmap = WIN_ONE;
            end else begin
                state_next.seen_bitmap = (bitmap_e << shift_amt[WIN_IDX_W-1:0]) | WIN_ONE;
            end
            state_next.window_top      = item.packet_counter;
            state_next.underflow_count = 4'd0;
            result.accepted            = 1'b1;
            result.verdict             = VERDICT_NEW_TOP;
        end else if (distance < WIN_SIZE_32) begin
            if ((bitmap_e & dist_bit) != '0) begin
                result.verdict = VERDICT_DUPLICATE;
            end else begin
                state_next.seen_bitmap = bitmap_e | dist_bit;
                result.accepted        = 1'b1;
                result.verdict         = VERDICT_IN_WINDOW;
            end
        end else begin
            result.verdict             = VERDICT_TOO_OLD;
            state_next.underflow_count = count_inc;
            if (count_inc >= cfg_q.underflow_limit) begin
                state_next.underflow_count = 4'd0;
                if (elapsed > cfg_q.regen_interval_ms) begin
                    state_next.last_regen_time = item.time_ms;
                    result.regen_request       = 1'b1;
                end
            end
        end
    end

endmodule

// File: design/anti_replay_window_check_top.sv
// ----------------------------------------------------------------------------
// anti_replay_window_check_top: 64-entry sliding anti-replay window check
// Registers each packet item, judges it combinationally against the window
// state and presents the verdict from an output register.
//
//   Channel   Direction   Contents
//   s_        in          current_nonce, packet_nonce, packet_counter, time_ms
//   m_        out         accepted, verdict, regen_request
//   cfg_      in          underflow_limit (0), regen_interval_ms (1)
//
// An item is judged from the input register and its result is presented from
// the output register; the rate is one item per cycle while m_tready is high.
// The window state is updated in the judging cycle, so consecutive items see
// each other's effect. Reset clears the window and loads the register
// defaults. A stall on the result side holds the input register and lowers
// s_tready only while both stages are full.
// ----------------------------------------------------------------------------
module anti_replay_window_check_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // current_nonce, packet_nonce, packet_counter, time_ms
    input  logic [arwc_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // accepted, verdict, regen_request, zero fill
    output logic [arwc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [arwc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [arwc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import arwc_pkg::*;

    logic       in_valid_reg;
    item_t      item_reg;
    logic       out_valid_reg;
    result_t    res_reg;
    logic       fire;
    win_state_t state_q;
    win_state_t state_next;
    cfg_t       cfg_q;
    result_t    result;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.current_nonce  <= s_tdata[31:0];
            item_reg.packet_nonce   <= s_tdata[63:32];
            item_reg.packet_counter <= s_tdata[95:64];
            item_reg.time_ms        <= s_tdata[127:96];
        end
        if (fire) begin
            res_reg <= result;
        end
    end

    arwc_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .upd_en     (fire),
        .state_next (state_next),
        .state_q    (state_q),
        .cfg_q      (cfg_q)
    );

    arwc_judge u_judge (
        .item       (item_reg),
        .state_q    (state_q),
        .cfg_q      (cfg_q),
        .state_next (state_next),
        .result     (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg.regen_request, res_reg.verdict, res_reg.accepted};

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !in_valid_reg)
        else $error("pipeline valid flags not cleared by reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.verdict == VERDICT_NEW_TOP
        |=> state_q.window_top == $past(item_reg.packet_counter) && state_q.seen_bitmap[0])
        else $error("window did not advance to the new top counter");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] == (m_tdata[3:1] == VERDICT_NEW_TOP
                                    || m_tdata[3:1] == VERDICT_IN_WINDOW))
        else $error("accepted flag disagrees with verdict");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[3:1] == VERDICT_TOO_OLD)
        else $error("regen request raised on a packet that is not too old");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !fire |=> in_valid_reg && $stable(item_reg))
        else $error("held item lost while the result side stalled");

endmodule
